/* src/csa_pkg.sv */
`timescale 1ns / 1ps

package csa_pkg;

    // Field widths of the request and response streams.
    localparam int KIND_W     = 2;
    localparam int VAR_W      = 16;
    localparam int SIZE_W     = 12;
    localparam int SLOT_OUT_W = 8;
    localparam int ERR_W      = 2;

    // A run length never exceeds the byte size it was rounded from.
    localparam int LEN_W = SIZE_W;

    // Stream packing.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TUSER_W = ERR_W + 1;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_SPACE   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TABLE_FULL = 2'd2;

    // Controller to owner table.
    typedef struct packed {
        logic scan_start;
        logic wr_en;
        logic wr_valid;
    } tbl_cmd_t;

    // Owner table to controller.
    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
        logic has_free;
    } tbl_stat_t;

    // Controller to slot map.
    typedef struct packed {
        logic fit_start;
        logic fill_start;
        logic fill_set;
    } map_cmd_t;

    // Slot map to controller.
    typedef struct packed {
        logic ready;
        logic done;
        logic fit_found;
    } map_stat_t;

endpackage

/* src/csa_owner_table.sv */
`timescale 1ns / 1ps

module csa_owner_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int START_W       = 8,
    parameter int RLEN_W        = 9
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  csa_pkg::tbl_cmd_t                   cmd,
    input  logic [csa_pkg::VAR_W-1:0]           key,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]    wr_idx,
    input  logic [START_W-1:0]                  wr_start,
    input  logic [RLEN_W-1:0]                   wr_len,
    output csa_pkg::tbl_stat_t                  stat,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    hit_idx,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    free_idx,
    output logic [START_W-1:0]                  hit_start,
    output logic [RLEN_W-1:0]                   hit_len
);
    import csa_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = 1 + VAR_W + START_W + RLEN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Entry word: {valid, variable, start, length}.
    logic [WORD_W-1:0] mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] rd_word_reg;

    logic              clr_busy_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic              issue_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic              done_reg;
    logic              hit_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [START_W-1:0] hit_start_reg;
    logic [RLEN_W-1:0] hit_len_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_word;
    logic              rd_valid;
    logic [VAR_W-1:0]  rd_var;
    logic [START_W-1:0] rd_start;
    logic [RLEN_W-1:0] rd_len;

    // The clearing pass after reset owns the write port until it is done.
    always_comb begin
        wr_en   = clr_busy_reg | cmd.wr_en;
        wr_addr = clr_busy_reg ? clr_addr_reg : wr_idx;
        wr_word = clr_busy_reg ? '0 : {cmd.wr_valid, key, wr_start, wr_len};
    end

    // Single-port write, registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= mem[rd_addr_reg];
    end

    assign rd_valid = rd_word_reg[WORD_W-1];
    assign rd_var   = rd_word_reg[WORD_W-2 -: VAR_W];
    assign rd_start = rd_word_reg[RLEN_W +: START_W];
    assign rd_len   = rd_word_reg[RLEN_W-1:0];

    // Linear scan: one read issued per cycle, the word is checked in the cycle after.
    // The first matching valid entry and the first invalid entry are kept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            issue_reg    <= 1'b0;
            rd_addr_reg  <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end else begin
            done_reg     <= 1'b0;
            pend_reg     <= issue_reg;
            pend_idx_reg <= rd_addr_reg;

            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX) begin
                    clr_busy_reg <= 1'b0;
                    clr_addr_reg <= '0;
                end
            end

            if (cmd.scan_start) begin
                issue_reg   <= 1'b1;
                rd_addr_reg <= '0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
            end else if (issue_reg) begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
                if (rd_addr_reg == LAST_IDX) begin
                    issue_reg   <= 1'b0;
                    rd_addr_reg <= '0;
                end
            end

            if (pend_reg) begin
                if (rd_valid && rd_var == key && !hit_reg) begin
                    hit_reg       <= 1'b1;
                    hit_idx_reg   <= pend_idx_reg;
                    hit_start_reg <= rd_start;
                    hit_len_reg   <= rd_len;
                end
                if (!rd_valid && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= pend_idx_reg;
                end
                if (pend_idx_reg == LAST_IDX) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.ready    = !clr_busy_reg;
    assign stat.done     = done_reg;
    assign stat.hit      = hit_reg;
    assign stat.has_free = free_reg;
    assign hit_idx       = hit_idx_reg;
    assign free_idx      = free_idx_reg;
    assign hit_start     = hit_start_reg;
    assign hit_len       = hit_len_reg;

`ifndef SYNTHESIS
    // A scan is only started on an idle, initialized table.
    a_scan_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> !clr_busy_reg && !issue_reg && !pend_reg)
        else $error("owner table scan started while busy");

    // Entry writes never collide with a scan or the clearing pass.
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !clr_busy_reg && !issue_reg && !pend_reg)
        else $error("owner table written while busy");

    // A matching entry is valid and a free one is not, so they cannot coincide.
    a_hit_free_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg && free_reg |-> hit_idx_reg != free_idx_reg)
        else $error("hit entry and free entry are the same");
`endif

endmodule

/* src/csa_slot_map.sv */
`timescale 1ns / 1ps

module csa_slot_map #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  csa_pkg::map_cmd_t                   cmd,
    input  logic [csa_pkg::LEN_W-1:0]           fit_len,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]      high_water,
    input  logic [$clog2(MAX_SLOTS)-1:0]        fill_start,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]      fill_count,
    output csa_pkg::map_stat_t                  stat,
    output logic [$clog2(MAX_SLOTS)-1:0]        fit_pos
);
    import csa_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SLOTS);
    localparam int HW_W   = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W  = ((HW_W > LEN_W) ? HW_W : LEN_W) + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SLOTS - 1);

    // One busy bit per slot.
    logic mem [MAX_SLOTS];
    logic rd_bit_reg;

    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              fill_busy_reg;
    logic [ADDR_W-1:0] fill_addr_reg;
    logic [HW_W-1:0]   fill_left_reg;
    logic              fill_set_reg;
    logic              fit_busy_reg;
    logic              issue_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] last_addr_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  run_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic              found_reg;
    logic              done_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_bit;
    logic [LEN_W-1:0]  run_inc;
    logic [LEN_W-1:0]  run_next;
    logic              run_hit;
    logic [ADDR_W-1:0] pos_calc;
    logic              too_long;

    // Write port: clearing pass first, then the fill sweep.
    always_comb begin
        wr_en   = clr_busy_reg | fill_busy_reg;
        wr_addr = clr_busy_reg ? clr_addr_reg : fill_addr_reg;
        wr_bit  = clr_busy_reg ? 1'b0 : fill_set_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
        rd_bit_reg <= mem[rd_addr_reg];
    end

    // Free-run counting: a run of len free slots ending at the checked slot.
    always_comb begin
        run_inc  = LEN_W'(run_reg + 1'b1);
        run_next = rd_bit_reg ? '0 : run_inc;
        run_hit  = !rd_bit_reg && (run_inc == len_reg);
        pos_calc = ADDR_W'(CMP_W'(pend_addr_reg) + CMP_W'(1) - CMP_W'(len_reg));
        too_long = CMP_W'(fit_len) > CMP_W'(high_water);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            fill_busy_reg <= 1'b0;
            fit_busy_reg  <= 1'b0;
            issue_reg     <= 1'b0;
            rd_addr_reg   <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            done_reg      <= 1'b0;
            pend_reg      <= issue_reg;
            pend_addr_reg <= rd_addr_reg;

            // Clearing pass after reset.
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                    clr_addr_reg <= '0;
                end
            end

            // Fill sweep: sets or clears one slot per cycle.
            if (cmd.fill_start) begin
                if (fill_count == '0) begin
                    done_reg <= 1'b1;
                end else begin
                    fill_busy_reg <= 1'b1;
                    fill_addr_reg <= fill_start;
                    fill_left_reg <= fill_count;
                    fill_set_reg  <= cmd.fill_set;
                end
            end else if (fill_busy_reg) begin
                fill_addr_reg <= fill_addr_reg + 1'b1;
                fill_left_reg <= fill_left_reg - 1'b1;
                if (fill_left_reg == HW_W'(1)) begin
                    fill_busy_reg <= 1'b0;
                    done_reg      <= 1'b1;
                end
            end

            // First-fit scan over slots below the high-water mark.
            if (cmd.fit_start) begin
                len_reg   <= fit_len;
                run_reg   <= '0;
                found_reg <= 1'b0;
                pos_reg   <= '0;
                if (fit_len == '0) begin
                    done_reg  <= 1'b1;
                    found_reg <= 1'b1;
                end else if (too_long) begin
                    done_reg <= 1'b1;
                end else begin
                    fit_busy_reg  <= 1'b1;
                    issue_reg     <= 1'b1;
                    rd_addr_reg   <= '0;
                    last_addr_reg <= ADDR_W'(high_water - 1'b1);
                end
            end else if (fit_busy_reg) begin
                if (issue_reg) begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                    if (rd_addr_reg == last_addr_reg) begin
                        issue_reg   <= 1'b0;
                        rd_addr_reg <= '0;
                    end
                end
                if (pend_reg) begin
                    run_reg <= run_next;
                    if (run_hit) begin
                        found_reg    <= 1'b1;
                        pos_reg      <= pos_calc;
                        done_reg     <= 1'b1;
                        fit_busy_reg <= 1'b0;
                        issue_reg    <= 1'b0;
                        rd_addr_reg  <= '0;
                    end else if (pend_addr_reg == last_addr_reg) begin
                        done_reg     <= 1'b1;
                        fit_busy_reg <= 1'b0;
                    end
                end
            end
        end
    end

    assign stat.ready     = !clr_busy_reg;
    assign stat.done      = done_reg;
    assign stat.fit_found = found_reg;
    assign fit_pos        = pos_reg;

`ifndef SYNTHESIS
    // Commands only arrive when the map is idle.
    a_cmd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fit_start || cmd.fill_start |-> !fit_busy_reg && !fill_busy_reg && !clr_busy_reg)
        else $error("slot map command while busy");

    // The scan and the fill sweep never run together.
    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fit_busy_reg && fill_busy_reg))
        else $error("scan and fill active together");

    // Scan reads stay below the high-water mark.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fit_busy_reg && issue_reg |-> rd_addr_reg <= last_addr_reg)
        else $error("scan address beyond high-water mark");
`endif

endmodule

/* src/contiguous_slot_allocator.sv */
`timescale 1ns / 1ps

// Contiguous stack-slot allocator with a first-fit search over a slot bitmap.
// Requests arrive on the s_ channel: s_tuser carries the kind (allocate, free,
// find), s_tdata the variable and the byte size. Each request gives exactly one
// response on the m_ channel: slot index in m_tdata, found and error in m_tuser.
// Requests are handled one at a time. Every request first scans the owner table,
// one entry per cycle. An allocate then scans the bitmap up to the high-water
// mark and marks the run, one slot per cycle; a free clears its recorded run
// the same way. The next request can be accepted in the same cycle as the
// response is presented. After reset both memories are swept to zero, one
// entry per cycle; s_tready stays low meanwhile.
// The response sits in an output register. When the receiver stalls, the next
// request is still taken and processed; its response waits until the register
// is free, and only then is a further request accepted.
module contiguous_slot_allocator #(
    parameter int MAX_SLOTS     = 256,
    parameter int TABLE_ENTRIES = 64,
    parameter int SLOT_BYTES    = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] variable_id, [27:16] size_bytes, [31:28] zero
    input  logic [csa_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] kind
    input  logic [csa_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] slot_index
    output logic [csa_pkg::SLOT_OUT_W-1:0]     m_tdata,
    // [0] found, [2:1] error_code
    output logic [csa_pkg::M_TUSER_W-1:0]      m_tuser
);
    import csa_pkg::*;

    localparam int ADDR_W   = $clog2(MAX_SLOTS);
    localparam int HW_W     = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int CMP_W    = ((HW_W > LEN_W) ? HW_W : LEN_W) + 1;
    // Round-up division by the slot size as a reciprocal multiply.
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int RECIP    = (2 ** RECIP_SH + SLOT_BYTES - 1) / SLOT_BYTES;
    localparam int NUM_W    = SIZE_W + 1;
    localparam int PROD_W   = NUM_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_FIT,
        ST_FILL,
        ST_RESULT
    } state_t;

    state_t               state_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [VAR_W-1:0]     var_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [HW_W-1:0]      hw_reg;
    tbl_cmd_t             tbl_cmd_reg;
    map_cmd_t             map_cmd_reg;
    logic [IDX_W-1:0]     wr_idx_reg;
    logic [ADDR_W-1:0]    wr_start_reg;
    logic [HW_W-1:0]      wr_len_reg;
    logic [ADDR_W-1:0]    fill_start_reg;
    logic [HW_W-1:0]      fill_count_reg;
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic                 res_found_reg;
    logic [ERR_W-1:0]     res_err_reg;
    logic                 m_tvalid_reg;
    logic [SLOT_OUT_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    tbl_stat_t            tbl_stat;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     free_idx;
    logic [ADDR_W-1:0]    hit_start;
    logic [HW_W-1:0]      hit_len;
    map_stat_t            map_stat;
    logic [ADDR_W-1:0]    fit_pos;

    logic [NUM_W-1:0]     num;
    logic [PROD_W-1:0]    prod;
    logic [LEN_W-1:0]     len_calc;
    logic [CMP_W-1:0]     app_end;
    logic                 space_ok;
    logic                 table_ok;
    logic [ADDR_W-1:0]    alloc_start;

    csa_owner_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .START_W       (ADDR_W),
        .RLEN_W        (HW_W)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (tbl_cmd_reg),
        .key       (var_reg),
        .wr_idx    (wr_idx_reg),
        .wr_start  (wr_start_reg),
        .wr_len    (wr_len_reg),
        .stat      (tbl_stat),
        .hit_idx   (hit_idx),
        .free_idx  (free_idx),
        .hit_start (hit_start),
        .hit_len   (hit_len)
    );

    csa_slot_map #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (map_cmd_reg),
        .fit_len    (len_reg),
        .high_water (hw_reg),
        .fill_start (fill_start_reg),
        .fill_count (fill_count_reg),
        .stat       (map_stat),
        .fit_pos    (fit_pos)
    );

    // Slot count: ceil(size / SLOT_BYTES), registered during the table scan.
    always_comb begin
        num      = NUM_W'(size_reg) + NUM_W'(SLOT_BYTES - 1);
        prod     = PROD_W'(num) * PROD_W'(RECIP_W'(RECIP));
        len_calc = prod[RECIP_SH +: LEN_W];
    end

    // Allocation decision once the first-fit scan is done.
    always_comb begin
        app_end     = CMP_W'(hw_reg) + CMP_W'(len_reg);
        space_ok    = map_stat.fit_found || (app_end <= CMP_W'(MAX_SLOTS));
        table_ok    = tbl_stat.hit || tbl_stat.has_free;
        alloc_start = map_stat.fit_found ? fit_pos : ADDR_W'(hw_reg);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Request sequencer and response register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            hw_reg       <= '0;
            tbl_cmd_reg  <= '0;
            map_cmd_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            tbl_cmd_reg <= '0;
            map_cmd_reg <= '0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT: begin
                    if (tbl_stat.ready && map_stat.ready) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg               <= s_tuser[KIND_W-1:0];
                        var_reg                <= s_tdata[VAR_W-1:0];
                        size_reg               <= s_tdata[VAR_W +: SIZE_W];
                        tbl_cmd_reg.scan_start <= 1'b1;
                        state_reg              <= ST_LOOKUP;
                    end
                end

                ST_LOOKUP: begin
                    len_reg <= len_calc;
                    if (tbl_stat.done) begin
                        res_slot_reg  <= '0;
                        res_found_reg <= 1'b0;
                        res_err_reg   <= ERR_NONE;
                        state_reg     <= ST_RESULT;
                        case (kind_reg)
                            KIND_ALLOC: begin
                                map_cmd_reg.fit_start <= 1'b1;
                                state_reg             <= ST_FIT;
                            end
                            KIND_FREE: begin
                                if (tbl_stat.hit) begin
                                    map_cmd_reg.fill_start <= 1'b1;
                                    map_cmd_reg.fill_set   <= 1'b0;
                                    fill_start_reg         <= hit_start;
                                    fill_count_reg         <= hit_len;
                                    tbl_cmd_reg.wr_en      <= 1'b1;
                                    tbl_cmd_reg.wr_valid   <= 1'b0;
                                    wr_idx_reg             <= hit_idx;
                                    wr_start_reg           <= hit_start;
                                    wr_len_reg             <= hit_len;
                                    res_slot_reg           <= SLOT_OUT_W'(hit_start);
                                    res_found_reg          <= 1'b1;
                                    state_reg              <= ST_FILL;
                                end
                            end
                            KIND_FIND: begin
                                if (tbl_stat.hit) begin
                                    res_slot_reg  <= SLOT_OUT_W'(hit_start);
                                    res_found_reg <= 1'b1;
                                end
                            end
                            default: begin
                                res_found_reg <= 1'b0;
                            end
                        endcase
                    end
                end

                ST_FIT: begin
                    if (map_stat.done) begin
                        if (!space_ok) begin
                            res_err_reg <= ERR_NO_SPACE;
                            state_reg   <= ST_RESULT;
                        end else if (!table_ok) begin
                            res_err_reg <= ERR_TABLE_FULL;
                            state_reg   <= ST_RESULT;
                        end else begin
                            map_cmd_reg.fill_start <= 1'b1;
                            map_cmd_reg.fill_set   <= 1'b1;
                            fill_start_reg         <= alloc_start;
                            fill_count_reg         <= HW_W'(len_reg);
                            if (!map_stat.fit_found) begin
                                hw_reg <= HW_W'(app_end);
                            end
                            // An existing entry keeps its old run.
                            if (!tbl_stat.hit) begin
                                tbl_cmd_reg.wr_en    <= 1'b1;
                                tbl_cmd_reg.wr_valid <= 1'b1;
                                wr_idx_reg           <= free_idx;
                                wr_start_reg         <= alloc_start;
                                wr_len_reg           <= HW_W'(len_reg);
                            end
                            res_slot_reg  <= SLOT_OUT_W'(alloc_start);
                            res_found_reg <= 1'b1;
                            state_reg     <= ST_FILL;
                        end
                    end
                end

                ST_FILL: begin
                    if (map_stat.done) begin
                        state_reg <= ST_RESULT;
                    end
                end

                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_slot_reg;
                        m_tuser_reg  <= {res_err_reg, res_found_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The high-water mark only grows between resets.
    a_hw_grows: assert property (@(posedge aclk)
        aresetn && $past(aresetn) |-> hw_reg >= $past(hw_reg))
        else $error("high-water mark decreased");

    // The high-water mark never passes the slot count.
    a_hw_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(hw_reg) <= CMP_W'(MAX_SLOTS))
        else $error("high-water mark beyond capacity");

    // A response never reports success together with an error.
    a_found_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0] |-> m_tuser_reg[M_TUSER_W-1:1] == ERR_NONE)
        else $error("found response carries an error");

    // Any response without a match reports slot zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg[0] |-> m_tdata_reg == '0)
        else $error("unmatched response with nonzero slot");
`endif

endmodule

/* tb/tb_contiguous_slot_allocator.sv */
`timescale 1ns / 1ps

module tb_contiguous_slot_allocator;

    import csa_pkg::*;

    localparam int MAX_SLOTS     = 256;
    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_BYTES    = 8;

    // The fourth encoding of the kind field is not an operation.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Worst-case cycles for one request, and the no-progress limit of the watchdog.
    localparam int REQ_LATENCY = TABLE_ENTRIES + 2 * MAX_SLOTS + 10;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  found;
        logic [ERR_W-1:0]      error_code;
    } alloc_resp_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SLOT_OUT_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // Shadow copy of the allocator state.
    bit                    slot_taken[MAX_SLOTS];
    int                    top_slot;
    bit                    owner_valid[TABLE_ENTRIES];
    logic [VAR_W-1:0]      owner_var[TABLE_ENTRIES];
    int                    owner_start[TABLE_ENTRIES];
    int                    owner_len[TABLE_ENTRIES];

    alloc_resp_t           pending_resp_q[$];
    alloc_resp_t           want;
    int                    mismatch_count;
    int                    stall_cycles;
    bit                    idle_off;

    // Statistics for the closing summary.
    int                    kind_count[4];
    int                    placed_count;
    int                    no_space_count;
    int                    table_full_count;

    contiguous_slot_allocator #(
        .MAX_SLOTS    (MAX_SLOTS),
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .SLOT_BYTES   (SLOT_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Index of the owner entry for a variable, or -1 when it holds none.
    function automatic int find_owner(input logic [VAR_W-1:0] var_id);
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (owner_valid[e] && owner_var[e] == var_id) begin
                return e;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow state and returns the response it must produce.
    function automatic alloc_resp_t predict_response(input logic [KIND_W-1:0] kind,
                                                     input logic [VAR_W-1:0] var_id,
                                                     input logic [SIZE_W-1:0] size_bytes);
        alloc_resp_t resp;
        int owner, spare, run_len, start, fit, s, i, e;
        bit append, clear;
        resp = '0;
        owner = find_owner(var_id);
        kind_count[kind]++;
        case (kind)
            KIND_ALLOC: begin
                run_len = int'(size_bytes) / SLOT_BYTES + ((int'(size_bytes) % SLOT_BYTES) != 0);
                // First fit inside the part of the bitmap below the high-water mark.
                fit = -1;
                if (run_len <= top_slot) begin
                    for (s = 0; s + run_len <= top_slot && fit < 0; s++) begin
                        clear = 1'b1;
                        for (i = 0; i < run_len; i++) begin
                            if (slot_taken[s + i]) begin
                                clear = 1'b0;
                            end
                        end
                        if (clear) begin
                            fit = s;
                        end
                    end
                end
                append = 1'b0;
                spare  = -1;
                start  = 0;
                if (fit >= 0) begin
                    start = fit;
                end else if (top_slot + run_len <= MAX_SLOTS) begin
                    start  = top_slot;
                    append = 1'b1;
                end else begin
                    resp.error_code = ERR_NO_SPACE;
                end
                // A new owner needs a free table entry; a known one keeps its old entry.
                if (resp.error_code == ERR_NONE && owner < 0) begin
                    for (e = 0; e < TABLE_ENTRIES && spare < 0; e++) begin
                        if (!owner_valid[e]) begin
                            spare = e;
                        end
                    end
                    if (spare < 0) begin
                        resp.error_code = ERR_TABLE_FULL;
                    end
                end
                if (resp.error_code == ERR_NONE) begin
                    for (i = 0; i < run_len; i++) begin
                        if (start + i < MAX_SLOTS) begin
                            slot_taken[start + i] = 1'b1;
                        end
                    end
                    if (append) begin
                        top_slot = start + run_len;
                    end
                    if (spare >= 0) begin
                        owner_valid[spare] = 1'b1;
                        owner_var[spare]   = var_id;
                        owner_start[spare] = start;
                        owner_len[spare]   = run_len;
                    end
                    resp.slot_index = SLOT_OUT_W'(start);
                    resp.found      = 1'b1;
                    placed_count++;
                end else if (resp.error_code == ERR_NO_SPACE) begin
                    no_space_count++;
                end else begin
                    table_full_count++;
                end
            end
            KIND_FREE: begin
                if (owner >= 0) begin
                    for (i = 0; i < owner_len[owner]; i++) begin
                        if (owner_start[owner] + i < MAX_SLOTS) begin
                            slot_taken[owner_start[owner] + i] = 1'b0;
                        end
                    end
                    owner_valid[owner] = 1'b0;
                    resp.slot_index    = SLOT_OUT_W'(owner_start[owner]);
                    resp.found         = 1'b1;
                    placed_count++;
                end
            end
            KIND_FIND: begin
                if (owner >= 0) begin
                    resp.slot_index = SLOT_OUT_W'(owner_start[owner]);
                    resp.found      = 1'b1;
                    placed_count++;
                end
            end
            default: begin
            end
        endcase
        return resp;
    endfunction

    // Byte sizes weighted toward small runs, with a tail reaching past the slot space.
    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) begin
            return SIZE_W'($urandom_range(64));
        end
        if (roll < 90) begin
            return SIZE_W'($urandom_range(512, 65));
        end
        if (roll < 97) begin
            return SIZE_W'($urandom_range(2048, 513));
        end
        return SIZE_W'($urandom_range(4095, 2049));
    endfunction

    // Presents one request, holds it until accepted, and queues its predicted response.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [VAR_W-1:0] var_id,
                                input logic [SIZE_W-1:0] size_bytes);
        @(negedge aclk);
        while (!idle_off && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - SIZE_W - VAR_W){1'b0}}, size_bytes, var_id};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_resp_q.insert(pending_resp_q.size(),
                              predict_response(kind, var_id, size_bytes));
    endtask

    // Lookups on an empty table and the unused kind.
    task automatic test_unknown_and_unused();
        send_request(KIND_FIND, 16'h0000, 12'h000);
        send_request(KIND_FREE, 16'hFFFF, 12'hFFF);
        send_request(KIND_UNUSED, 16'hFFFF, 12'hFFF);
    endtask

    // Rounding, first fit into a hole, append, zero size, re-allocation of a
    // held variable, running out of slot space, and a free that keeps the mark.
    task automatic test_alloc_cases();
        send_request(KIND_ALLOC, 16'h0000, 12'd0);
        send_request(KIND_ALLOC, 16'h0001, 12'd1);
        send_request(KIND_ALLOC, 16'h0002, 12'd8);
        send_request(KIND_ALLOC, 16'h0003, 12'd9);
        send_request(KIND_ALLOC, 16'h0001, 12'd16);
        send_request(KIND_FIND, 16'h0001, 12'd0);
        send_request(KIND_FREE, 16'h0002, 12'd0);
        send_request(KIND_ALLOC, 16'h0004, 12'd8);
        send_request(KIND_FREE, 16'h0000, 12'd0);
        send_request(KIND_ALLOC, 16'hFFFF, 12'd2048);
        send_request(KIND_ALLOC, 16'h0005, 12'd4095);
        send_request(KIND_ALLOC, 16'h0005, 12'd2000);
        send_request(KIND_ALLOC, 16'h0006, 12'd8);
        send_request(KIND_FREE, 16'h0005, 12'd0);
        send_request(KIND_ALLOC, 16'h0006, 12'd8);
        send_request(KIND_FIND, 16'h0006, 12'd0);
        send_request(KIND_FREE, 16'h0003, 12'd0);
        send_request(KIND_FREE, 16'h0001, 12'd0);
        send_request(KIND_FREE, 16'h0004, 12'd0);
        send_request(KIND_FREE, 16'h0006, 12'd0);
        send_request(KIND_FREE, 16'hFFFF, 12'd0);
    endtask

    // Fills the owner table with fresh variables until it overflows, then frees them all.
    task automatic test_table_full();
        logic [VAR_W-1:0] fresh_id;
        logic [VAR_W-1:0] held_ids[$];
        int n;
        idle_off = 1'b1;
        for (n = 0; n < TABLE_ENTRIES + 3; n++) begin
            do begin
                fresh_id = VAR_W'($urandom);
            end while (find_owner(fresh_id) >= 0);
            send_request(KIND_ALLOC, fresh_id, SIZE_W'($urandom_range(SLOT_BYTES)));
        end
        for (n = 0; n < TABLE_ENTRIES; n++) begin
            if (owner_valid[n]) begin
                held_ids.insert(held_ids.size(), owner_var[n]);
            end
        end
        foreach (held_ids[k]) begin
            send_request(KIND_FREE, held_ids[k], SIZE_W'($urandom_range(4095)));
        end
        idle_off = 1'b0;
    endtask

    // Allocate, free and find over a small pool of variables, with some noise.
    task automatic test_random_traffic(input int num_requests);
        logic [VAR_W-1:0] pool[40];
        logic [VAR_W-1:0] var_id;
        int roll, n;
        foreach (pool[k]) begin
            pool[k] = VAR_W'($urandom);
        end
        for (n = 0; n < num_requests; n++) begin
            roll   = $urandom_range(99);
            var_id = pool[$urandom_range(39)];
            if (roll < 40) begin
                // Re-allocating a held variable leaks its new run, so keep it rare.
                if (find_owner(var_id) >= 0 && $urandom_range(9) != 0) begin
                    send_request(KIND_FREE, var_id, SIZE_W'($urandom_range(4095)));
                end else begin
                    send_request(KIND_ALLOC, var_id, pick_size());
                end
            end else if (roll < 68) begin
                send_request(KIND_FREE, var_id, SIZE_W'($urandom_range(4095)));
            end else if (roll < 88) begin
                send_request(KIND_FIND, var_id, SIZE_W'($urandom_range(4095)));
            end else if (roll < 94) begin
                send_request(KIND_UNUSED, VAR_W'($urandom), SIZE_W'($urandom_range(4095)));
            end else begin
                send_request(KIND_W'($urandom_range(2)), VAR_W'($urandom), pick_size());
            end
        end
    endtask

    // The receiver stalls at random except during the no-idle stretch.
    always @(negedge aclk) begin
        m_tready <= idle_off || ($urandom_range(99) >= 21);
    end

    // Compare each delivered response with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_resp_q.size() == 0) begin
                $error("Unexpected response: slot_index %0d, found %0d, error_code %0d",
                       m_tdata, m_tuser[0], m_tuser[2:1]);
                mismatch_count++;
            end else begin
                want = pending_resp_q.pop_front();
                if (m_tdata !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[2:1] !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d", want.error_code, m_tuser[2:1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        idle_off       = 1'b0;
        top_slot       = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_unknown_and_unused();
        test_alloc_cases();
        test_table_full();
        test_random_traffic(350);

        // Drain the outstanding responses, then watch for stray ones.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_resp_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (REQ_LATENCY) @(posedge aclk);

        $display("Sent %0d allocates, %0d frees, %0d finds and %0d requests of the unused kind.",
                 kind_count[KIND_ALLOC], kind_count[KIND_FREE], kind_count[KIND_FIND],
                 kind_count[KIND_UNUSED]);
        $display("%0d requests succeeded, %0d ran out of slot space, %0d hit a full table.",
                 placed_count, no_space_count, table_full_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* contiguous_slot_allocator.f */
src/csa_pkg.sv
src/csa_owner_table.sv
src/csa_slot_map.sv
src/contiguous_slot_allocator.sv
tb/tb_contiguous_slot_allocator.sv
